### rtl/siph_pkg.sv
// Shared constants, lane types and SipRound functions for the SipHash-2-4 stream unit.
package siph_pkg;

    // Standard SipHash initialisation constants and the finalisation XOR
    localparam logic [63:0] SIP_INIT_A    = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_INIT_B    = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_INIT_C    = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_INIT_D    = 64'h7465646279746573;
    localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_KEY_LOW  = 1'b0,
        CFG_KEY_HIGH = 1'b1
    } t_cfg_idx;

    // The four SipHash lanes
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_lanes;

    // Finalisation request from the absorb stage
    typedef struct packed {
        logic   valid;
        t_lanes lanes;
    } t_fin_req;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic t_lanes sip_round(input t_lanes s);
        t_lanes v;
        v   = s;
        v.a = v.a + v.b;
        v.b = rotl(v.b, 13) ^ v.a;
        v.a = rotl(v.a, 32);
        v.c = v.c + v.d;
        v.d = rotl(v.d, 16) ^ v.c;
        v.a = v.a + v.d;
        v.d = rotl(v.d, 21) ^ v.a;
        v.c = v.c + v.b;
        v.b = rotl(v.b, 17) ^ v.c;
        v.c = rotl(v.c, 32);
        return v;
    endfunction

    function automatic t_lanes sip_round2(input t_lanes s);
        return sip_round(sip_round(s));
    endfunction

endpackage

### rtl/siph_in_if.sv
// Message word channel: valid/ready handshake with one message beat as payload.
interface siph_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_word;
    logic        is_last;
    logic [2:0]  tail_bytes;

    modport source (output valid, msg_word, is_last, tail_bytes, input ready);
    modport sink   (input valid, msg_word, is_last, tail_bytes, output ready);
endinterface

### rtl/siph_out_if.sv
// Hash result channel: valid/ready handshake with the 64-bit hash as payload.
interface siph_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

### rtl/siph_absorb.sv
// Absorb stage: input register, lane state, byte count and two SipRounds per beat.
module siph_absorb
    import siph_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    siph_in_if.sink      i_msg,
    input  logic [63:0]  i_key_low,
    input  logic [63:0]  i_key_high,
    output t_fin_req     o_fin,
    input  logic         i_fin_ready
);

    logic        r_s0_valid;
    logic [63:0] r_word;
    logic        r_last;
    logic [2:0]  r_tail;
    t_lanes      r_lanes;
    logic [7:0]  r_len;
    logic        r_in_msg;

    t_lanes      src_lanes;
    t_lanes      n_lanes;
    t_lanes      mixed;
    logic [7:0]  src_len;
    logic [7:0]  n_len;
    logic [63:0] tail_mask;
    logic [63:0] block;
    logic        s0_adv;
    logic        s0_free;

    // Build the block, mix it in with two rounds
    always_comb begin
        src_lanes.a = SIP_INIT_A ^ i_key_low;
        src_lanes.b = SIP_INIT_B ^ i_key_high;
        src_lanes.c = SIP_INIT_C ^ i_key_low;
        src_lanes.d = SIP_INIT_D ^ i_key_high;
        if (r_in_msg) begin
            src_lanes = r_lanes;
        end
        src_len = r_in_msg ? r_len : 8'd0;
        n_len   = src_len + (r_last ? {5'd0, r_tail} : 8'd8);

        for (int i = 0; i < 8; i++) begin
            tail_mask[8*i +: 8] = (3'(i) < r_tail) ? 8'hff : 8'h00;
        end
        block = r_last ? ((r_word & tail_mask) | {n_len, 56'd0}) : r_word;

        mixed   = src_lanes;
        mixed.d = mixed.d ^ block;
        mixed   = sip_round2(mixed);
        mixed.a = mixed.a ^ block;
        n_lanes = mixed;
    end

    // Handshake: a full word always retires, a last beat waits for the final stage
    assign s0_adv      = r_s0_valid && (!r_last || i_fin_ready);
    assign s0_free     = !r_s0_valid || s0_adv;
    assign i_msg.ready = s0_free;

    always_comb begin
        o_fin.valid     = r_s0_valid && r_last;
        o_fin.lanes     = n_lanes;
        o_fin.lanes.c   = n_lanes.c ^ SIP_FINAL_XOR;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_in_msg   <= 1'b0;
        end else begin
            if (s0_free) begin
                r_s0_valid <= i_msg.valid;
            end
            if (s0_adv) begin
                r_in_msg <= !r_last;
            end
        end
    end

    // Payload and lane registers
    always_ff @(posedge i_clk) begin
        if (i_msg.valid && s0_free) begin
            r_word <= i_msg.msg_word;
            r_last <= i_msg.is_last;
            r_tail <= i_msg.tail_bytes;
        end
        if (s0_adv) begin
            r_lanes <= n_lanes;
            r_len   <= n_len;
        end
    end

endmodule

### rtl/siph_final.sv
// Finalisation pipeline: four SipRounds over two stages, fold and output register.
module siph_final
    import siph_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_fin_req     i_fin,
    output logic         o_fin_ready,
    siph_out_if.source   o_hash
);

    logic        r_f1_valid;
    t_lanes      r_f1_lanes;
    logic        r_f2_valid;
    t_lanes      r_f2_lanes;
    logic        r_out_valid;
    logic [63:0] r_hash;

    t_lanes      n_f2_lanes;
    t_lanes      f2_mixed;
    logic [63:0] n_hash;
    logic        out_free;
    logic        f2_free;
    logic        f1_free;

    // Stage occupancy: a stage moves on when the one after it is free
    assign out_free    = !r_out_valid || o_hash.ready;
    assign f2_free     = !r_f2_valid || out_free;
    assign f1_free     = !r_f1_valid || f2_free;
    assign o_fin_ready = f1_free;

    always_comb begin
        n_f2_lanes = sip_round2(r_f1_lanes);
        f2_mixed   = sip_round2(r_f2_lanes);
        n_hash     = f2_mixed.a ^ f2_mixed.b ^ f2_mixed.c ^ f2_mixed.d;
    end

    assign o_hash.valid      = r_out_valid;
    assign o_hash.hash_value = r_hash;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid  <= 1'b0;
            r_f2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (f1_free) begin
                r_f1_valid <= i_fin.valid;
            end
            if (f2_free) begin
                r_f2_valid <= r_f1_valid;
            end
            if (out_free) begin
                r_out_valid <= r_f2_valid;
            end
        end
    end

    // Payload: advance each stage only when it takes a new beat
    always_ff @(posedge i_clk) begin
        if (i_fin.valid && f1_free) begin
            r_f1_lanes <= i_fin.lanes;
        end
        if (r_f1_valid && f2_free) begin
            r_f2_lanes <= n_f2_lanes;
        end
        if (r_f2_valid && out_free) begin
            r_hash <= n_hash;
        end
    end

endmodule

### rtl/siphash_2_4_stream_unit.sv
// SipHash-2-4 stream unit: key registers, absorb stage and finalisation pipeline.
//
// Usage: write the two 64-bit key words through i_cfg_we/i_cfg_index/i_cfg_wdata
// while the unit is idle (index 0 = low key word, index 1 = high key word).
// Message beats arrive on i_msg: each full 8-byte little-endian word has
// is_last low; a message ends with one beat that has is_last high and carries
// 0 to 7 tail bytes in its low bytes (tail_bytes gives the count). The first
// beat after reset or after a last beat opens a new message from the keys.
// One beat is taken every cycle while no last beat waits on the final stage;
// the absorb stage does two SipRounds per beat and the lane registers feed back
// into it, which sets that rate. Each last beat yields one 64-bit hash on o_hash
// via the f1, f2 and output registers; full words yield nothing. The four closing
// rounds run in two pipeline stages, so several messages may be in flight.
// When the receiver stalls, results back up stage by stage; i_msg.ready only
// drops once a last beat cannot move into a full finalisation pipeline.
// Reset clears the keys, all valid bits and the open-message flag.
module siphash_2_4_stream_unit
    import siph_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    siph_in_if.sink      i_msg,
    siph_out_if.source   o_hash,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_wdata
);

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    t_fin_req    fin_req;
    logic        fin_ready;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= 64'd0;
            r_key_high <= 64'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    siph_absorb u_absorb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_msg       (i_msg),
        .i_key_low   (r_key_low),
        .i_key_high  (r_key_high),
        .o_fin       (fin_req),
        .i_fin_ready (fin_ready)
    );

    siph_final u_final (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin       (fin_req),
        .o_fin_ready (fin_ready),
        .o_hash      (o_hash)
    );

    // Input stalls only when the whole finalisation path is backed up
    a_in_stall_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_msg.ready |-> (o_hash.valid && !o_hash.ready))
        else $error("input stalled without an output stall");

    // Finalisation request blocked only behind a stalled result
    a_fin_stall_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_req.valid && !fin_ready) |-> (o_hash.valid && !o_hash.ready))
        else $error("finalisation blocked without an output stall");

    // A blocked finalisation request stays pending
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_req.valid && !fin_ready) |=> fin_req.valid)
        else $error("pending finalisation request dropped");

endmodule

### tb/sv/siphash_2_4_stream_unit_test.sv
// Self-checking testbench for the SipHash-2-4 stream unit: directed table, then random messages.
module siphash_2_4_stream_unit_test;
    import siph_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BEATS  = 400;
    localparam int RUN_LIMIT    = 3_200_000;

    typedef enum logic [0:0] {
        ROW_BEAT,
        ROW_KEY
    } row_kind_e;

    typedef struct {
        row_kind_e   kind;
        logic [63:0] word;
        logic        last;
        logic [2:0]  tail;
        t_cfg_idx    key_idx;
        bit          known_ok;
        logic [63:0] known_hash;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_wdata;

    siph_in_if  msg_if ();
    siph_out_if hash_if ();

    siphash_2_4_stream_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_msg       (msg_if),
        .o_hash      (hash_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predictor state: key copy, lanes, byte count and open-message flag
    logic [63:0] key_lo_m;
    logic [63:0] key_hi_m;
    t_lanes      lanes_m;
    logic [7:0]  byte_count_m;
    bit          msg_open_m;

    logic [63:0] pending_hashes[$];
    dir_row_t    dir_rows[$];
    int unsigned err_count = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Rotate left by slicing a doubled copy of the word
    function automatic logic [63:0] rot64(input logic [63:0] x, input int r);
        logic [127:0] dbl;
        dbl = {x, x};
        return dbl[(127 - r) -: 64];
    endfunction

    function automatic t_lanes sip_mix(input t_lanes v);
        v.a += v.b;
        v.b = rot64(v.b, 13) ^ v.a;
        v.a = rot64(v.a, 32);
        v.c += v.d;
        v.d = rot64(v.d, 16) ^ v.c;
        v.a += v.d;
        v.d = rot64(v.d, 21) ^ v.a;
        v.c += v.b;
        v.b = rot64(v.b, 17) ^ v.c;
        v.c = rot64(v.c, 32);
        return v;
    endfunction

    function automatic void absorb_word(input logic [63:0] m);
        lanes_m.d ^= m;
        lanes_m = sip_mix(sip_mix(lanes_m));
        lanes_m.a ^= m;
    endfunction

    // Advance the predicted hash state by one beat; return 1 when a hash is due
    function automatic bit hash_step(input logic [63:0] word, input logic last,
                                     input logic [2:0] tail, output logic [63:0] hash);
        logic [63:0] keep;
        hash = '0;
        if (!msg_open_m) begin
            lanes_m.a    = SIP_INIT_A ^ key_lo_m;
            lanes_m.b    = SIP_INIT_B ^ key_hi_m;
            lanes_m.c    = SIP_INIT_C ^ key_lo_m;
            lanes_m.d    = SIP_INIT_D ^ key_hi_m;
            byte_count_m = '0;
            msg_open_m   = 1'b1;
        end
        if (!last) begin
            absorb_word(word);
            byte_count_m += 8'd8;
            return 1'b0;
        end
        // Mask bytes at and above the count, put the length in the top byte
        byte_count_m += 8'(tail);
        keep = (64'd1 << (8 * tail)) - 64'd1;
        absorb_word((word & keep) | {byte_count_m, 56'd0});
        lanes_m.c ^= SIP_FINAL_XOR;
        repeat (4) lanes_m = sip_mix(lanes_m);
        hash       = lanes_m.a ^ lanes_m.b ^ lanes_m.c ^ lanes_m.d;
        msg_open_m = 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_beat(input logic [63:0] word, input logic last,
                                     input logic [2:0] tail, input bit known_ok,
                                     input logic [63:0] known_hash);
        dir_row_t r;
        r.kind       = ROW_BEAT;
        r.word       = word;
        r.last       = last;
        r.tail       = tail;
        r.key_idx    = CFG_KEY_LOW;
        r.known_ok   = known_ok;
        r.known_hash = known_hash;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_key(input t_cfg_idx idx, input logic [63:0] val);
        dir_row_t r;
        r.kind       = ROW_KEY;
        r.word       = val;
        r.last       = 1'b0;
        r.tail       = '0;
        r.key_idx    = idx;
        r.known_ok   = 1'b0;
        r.known_hash = '0;
        dir_rows.push_back(r);
    endfunction

    // Offer one message beat after a random gap and record its effect once taken
    task automatic send_beat(input logic [63:0] word, input logic last, input logic [2:0] tail,
                             input bit known_ok, input logic [63:0] known_hash, input bit no_gap);
        int unsigned gap;
        logic [63:0] hash;
        gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            msg_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        msg_if.valid      <= 1'b1;
        msg_if.msg_word   <= word;
        msg_if.is_last    <= last;
        msg_if.tail_bytes <= tail;
        do @(posedge i_clk); while (!(msg_if.valid && msg_if.ready));
        if (hash_step(word, last, tail, hash))
            pending_hashes.push_back(known_ok ? known_hash : hash);
    endtask

    // Hold the sender until every hash is out, then let the pipeline settle
    task automatic quiesce();
        @(negedge i_clk);
        msg_if.valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key(input t_cfg_idx idx, input logic [63:0] val);
        quiesce();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY_LOW)
            key_lo_m = val;
        else
            key_hi_m = val;
    endtask

    task automatic send_message(input int words, input bit no_gap);
        for (int w = 0; w < words; w++) begin
            send_beat({$urandom, $urandom}, 1'b0, 3'($urandom_range(0, 7)), 1'b0, '0, no_gap);
        end
        send_beat({$urandom, $urandom}, 1'b1, 3'($urandom_range(0, 7)), 1'b0, '0, no_gap);
    endtask

    // Sink side: random stalls, compare each hash beat with the oldest expectation
    initial begin : hash_sink
        int unsigned stall;
        int unsigned run_left;
        bit          quiet;
        logic [63:0] want;
        hash_if.ready = 1'b0;
        run_left      = 0;
        quiet         = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (run_left == 0) begin
                quiet    = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(1, 12);
            end
            run_left--;
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                @(negedge i_clk);
                hash_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            hash_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(hash_if.valid && hash_if.ready));
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected hash: expected none, got %h", $time,
                         hash_if.hash_value);
                err_count++;
            end else begin
                want = pending_hashes.pop_front();
                if (hash_if.hash_value !== want) begin
                    $display("%0t: hash mismatch: expected %h, got %h", $time, want,
                             hash_if.hash_value);
                    err_count++;
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #RUN_LIMIT;
        $display("siphash_2_4_stream_unit_test: errors");
        $finish;
    end

    initial begin : stimulus
        int          words;
        int          beats;
        bit          no_gap;
        logic [63:0] phase_lo;
        logic [63:0] phase_hi;

        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_KEY_LOW;
        cfg_wdata         = '0;
        msg_if.valid      = 1'b0;
        msg_if.msg_word   = '0;
        msg_if.is_last    = 1'b0;
        msg_if.tail_bytes = '0;
        key_lo_m          = '0;
        key_hi_m          = '0;
        lanes_m           = '0;
        byte_count_m      = '0;
        msg_open_m        = 1'b0;

        // Empty message under the reset keys; set bytes at and above the count are dropped
        add_beat(64'hffff_ffff_ffff_ffff, 1'b1, 3'd0, 1'b0, '0);
        // Standard test key 00..0f: empty message and the 15-byte example
        add_key(CFG_KEY_LOW, 64'h0706050403020100);
        add_key(CFG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        add_beat(64'h0, 1'b1, 3'd0, 1'b1, 64'h726fdb47dd0e0e31);
        add_beat(64'h0706050403020100, 1'b0, 3'd5, 1'b0, '0);
        add_beat(64'hff0e0d0c0b0a0908, 1'b1, 3'd7, 1'b1, 64'ha129ca6149be45e5);
        // Extremes of the message word
        add_beat(64'hffff_ffff_ffff_ffff, 1'b0, 3'd7, 1'b0, '0);
        add_beat(64'hffff_ffff_ffff_ffff, 1'b1, 3'd7, 1'b0, '0);
        add_beat(64'h0, 1'b0, 3'd0, 1'b0, '0);
        add_beat(64'h0, 1'b1, 3'd7, 1'b0, '0);
        // Key change inside an open message only applies to the next one
        add_beat(64'h0123456789abcdef, 1'b0, 3'd2, 1'b0, '0);
        add_key(CFG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
        add_beat(64'hfedcba9876543210, 1'b1, 3'd3, 1'b0, '0);
        add_key(CFG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
        add_beat(64'ha5a5_a5a5_a5a5_a5a5, 1'b1, 3'd0, 1'b0, '0);
        // Single-beat messages over the remaining tail counts
        for (int t = 1; t <= 6; t++) begin
            add_beat(64'h8877665544332211 ^ {8{8'(t * 37)}}, 1'b1, 3'(t), 1'b0, '0);
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_KEY)
                write_key(dir_rows[i].key_idx, dir_rows[i].word);
            else
                send_beat(dir_rows[i].word, dir_rows[i].last, dir_rows[i].tail,
                          dir_rows[i].known_ok, dir_rows[i].known_hash, 1'b0);
        end

        // Random messages under several key settings, sender drained between phases
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    phase_lo = '0;
                    phase_hi = '0;
                end
                2: begin
                    phase_lo = '1;
                    phase_hi = '1;
                end
                3: begin
                    phase_lo = '1;
                    phase_hi = '0;
                end
                default: begin
                    phase_lo = {$urandom, $urandom};
                    phase_hi = {$urandom, $urandom};
                end
            endcase
            write_key(CFG_KEY_LOW, phase_lo);
            write_key(CFG_KEY_HIGH, phase_hi);
            beats = 0;
            while (beats < PHASE_BEATS) begin
                no_gap = ($urandom_range(0, 3) == 0);
                // Open with a message past 256 bytes so the length byte wraps
                if (ph == 0 && beats == 0)
                    words = 33;
                else if ($urandom_range(0, 19) == 0)
                    words = $urandom_range(32, 40);
                else
                    words = $urandom_range(0, 8);
                send_message(words, no_gap);
                beats += words + 1;
            end
        end

        quiesce();
        if (err_count == 0)
            $display("siphash_2_4_stream_unit_test: clean");
        else
            $display("siphash_2_4_stream_unit_test: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/siph_pkg.sv
rtl/siph_in_if.sv
rtl/siph_out_if.sv
rtl/siph_absorb.sv
rtl/siph_final.sv
rtl/siphash_2_4_stream_unit.sv
tb/sv/siphash_2_4_stream_unit_test.sv
